/* src/rmbl_pkg.sv */
// ----------------------------------------------------------------------------
// rmbl_pkg
// Shared widths, register indexes and label codes of the region mask core.
// ----------------------------------------------------------------------------
package rmbl_pkg;

  localparam int CoordW  = 12;
  localparam int DimW    = 13;
  localparam int ExtW    = 14;
  localparam int LabelW  = 2;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 13;
  localparam int MaxDim  = 4096;

  localparam int HalfW   = CoordW - 1;
  localparam int HalfSqW = 2 * HalfW;
  localparam int AbsW    = ExtW - 1;
  localparam int SqW     = 2 * AbsW;
  localparam int PrW     = SqW + HalfSqW;
  localparam int AbSqW   = 2 * HalfSqW;

  typedef enum logic [CfgIdxW-1:0] {
    RegShapeMode    = 3'd0,
    RegRegionLeft   = 3'd1,
    RegRegionTop    = 3'd2,
    RegRegionRight  = 3'd3,
    RegRegionBottom = 3'd4,
    RegImageWidth   = 3'd5,
    RegImageHeight  = 3'd6
  } rmbl_reg_e;

  localparam logic [LabelW-1:0] LabelOutside = 2'd0;
  localparam logic [LabelW-1:0] LabelInside  = 2'd1;
  localparam logic [LabelW-1:0] LabelBorder  = 2'd2;

endpackage

/* src/region_mask_with_boundary_label_core.sv */
// ----------------------------------------------------------------------------
// region_mask_with_boundary_label_core
// Labels each pixel coordinate against a rectangle or inscribed ellipse.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: present pixel_x_i / pixel_y_i with start_i; the
//   coordinate is taken at a rising edge with start_i high and busy_o low.
//   busy_o stays low, so one pixel can be taken every clock cycle.
//   Result channel: region_label_o is valid for one cycle with done_o high,
//   once the pixel has passed the register stages listed below, in command order.
//   Throughput is one pixel per cycle; the six register stages are
//   coordinate capture, offsets and bounds, squaring, scaling by the
//   squared half axes, the ellipse compare and the label register.
//   Configuration: a write transfers at a rising edge with cfg_valid_i and
//   cfg_ready_o high; cfg_ready_o is always high. Write only while no
//   pixel is in flight.
//   Reset (rst_ni low) empties the pipeline and restores the registers:
//   rectangle mode, zero box, image size 4096 by 4096.
//   The receiver cannot stall: every result is shown exactly once.
// ----------------------------------------------------------------------------
module region_mask_with_boundary_label_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [rmbl_pkg::CoordW-1:0]    pixel_x_i,
  input  logic [rmbl_pkg::CoordW-1:0]    pixel_y_i,
  output logic                           done_o,
  output logic [rmbl_pkg::LabelW-1:0]    region_label_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rmbl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rmbl_pkg::CfgDatW-1:0]   cfg_data_i
);
  import rmbl_pkg::*;

  // configuration registers
  logic              shape_mode_q;
  logic [CoordW-1:0] left_q, top_q, right_q, bottom_q;
  logic [DimW-1:0]   width_q, height_q;

  // derived region constants
  logic [HalfW-1:0]   ha, hb;
  logic [CoordW-1:0]  diff_x, diff_y, cx, cy;
  logic [DimW-1:0]    wlim, hlim;
  logic [HalfSqW-1:0] ha_sq_q, hb_sq_q;
  logic [AbSqW-1:0]   ab_sq_q;
  logic               axes_nz_q;

  // pipeline
  logic              s1_v_q;
  logic [CoordW-1:0] s1_x_q, s1_y_q;

  logic              s2_v_q;
  logic [2:0]        s2_xok_q, s2_xbox_q, s2_yok_q, s2_ybox_q;
  logic [AbsW-1:0]   s2_adx_q [3];
  logic [AbsW-1:0]   s2_ady_q [3];

  logic              s3_v_q;
  logic [2:0]        s3_xok_q, s3_xbox_q, s3_yok_q, s3_ybox_q;
  logic [SqW-1:0]    s3_sqx_q [3];
  logic [SqW-1:0]    s3_sqy_q [3];

  logic              s4_v_q;
  logic [2:0]        s4_xok_q, s4_xbox_q, s4_yok_q, s4_ybox_q;
  logic [PrW-1:0]    s4_prx_q [3];
  logic [PrW-1:0]    s4_pry_q [3];

  logic              s5_v_q;
  logic              s5_img_q;
  logic [4:0]        s5_in_q;
  logic [4:0]        s5_in_d;

  logic              done_q;
  logic [LabelW-1:0] label_q, label_d;

  logic signed [ExtW-1:0] px [3];
  logic signed [ExtW-1:0] py [3];
  logic signed [ExtW-1:0] ddx [3];
  logic signed [ExtW-1:0] ddy [3];
  logic [2:0]             xok_d, xbox_d, yok_d, ybox_d;
  logic [AbsW-1:0]        adx_d [3];
  logic [AbsW-1:0]        ady_d [3];

  assign busy_o         = 1'b0;
  assign cfg_ready_o    = 1'b1;
  assign done_o         = done_q;
  assign region_label_o = label_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_mode_q <= 1'b0;
      left_q       <= '0;
      top_q        <= '0;
      right_q      <= '0;
      bottom_q     <= '0;
      width_q      <= DimW'(MaxDim);
      height_q     <= DimW'(MaxDim);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (rmbl_reg_e'(cfg_index_i))
        RegShapeMode:    shape_mode_q <= cfg_data_i[0];
        RegRegionLeft:   left_q       <= cfg_data_i[CoordW-1:0];
        RegRegionTop:    top_q        <= cfg_data_i[CoordW-1:0];
        RegRegionRight:  right_q      <= cfg_data_i[CoordW-1:0];
        RegRegionBottom: bottom_q     <= cfg_data_i[CoordW-1:0];
        RegImageWidth:   width_q      <= cfg_data_i[DimW-1:0];
        RegImageHeight:  height_q     <= cfg_data_i[DimW-1:0];
        default: ;
      endcase
    end
  end

  assign diff_x = right_q - left_q;
  assign diff_y = bottom_q - top_q;
  assign ha     = diff_x[CoordW-1:1];
  assign hb     = diff_y[CoordW-1:1];
  assign cx     = left_q + {1'b0, ha};
  assign cy     = top_q + {1'b0, hb};
  assign wlim   = (width_q > DimW'(MaxDim)) ? DimW'(MaxDim) : width_q;
  assign hlim   = (height_q > DimW'(MaxDim)) ? DimW'(MaxDim) : height_q;

  always_ff @(posedge clk_i) begin
    ha_sq_q   <= ha * ha;
    hb_sq_q   <= hb * hb;
    axes_nz_q <= (ha != '0) && (hb != '0);
    ab_sq_q   <= ha_sq_q * hb_sq_q;
  end

  // offsets and bounds for columns x-1, x, x+1 and rows y-1, y, y+1
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      px[i]  = $signed({2'b00, s1_x_q}) + ExtW'(i) - ExtW'(1);
      py[i]  = $signed({2'b00, s1_y_q}) + ExtW'(i) - ExtW'(1);
      ddx[i] = px[i] - $signed({2'b00, cx});
      ddy[i] = py[i] - $signed({2'b00, cy});
      adx_d[i] = ddx[i][ExtW-1] ? AbsW'(-ddx[i]) : ddx[i][AbsW-1:0];
      ady_d[i] = ddy[i][ExtW-1] ? AbsW'(-ddy[i]) : ddy[i][AbsW-1:0];
      xok_d[i] = !px[i][ExtW-1] && (px[i] < $signed({1'b0, wlim}));
      yok_d[i] = !py[i][ExtW-1] && (py[i] < $signed({1'b0, hlim}));
      xbox_d[i] = (px[i] >= $signed({2'b00, left_q})) &&
                  (px[i] <= $signed({2'b00, right_q}));
      ybox_d[i] = (py[i] >= $signed({2'b00, top_q})) &&
                  (py[i] <= $signed({2'b00, bottom_q}));
    end
  end

  function automatic logic pt_hit(logic xok, logic xbox, logic yok, logic ybox,
                                  logic rect, logic nz, logic [PrW-1:0] ex,
                                  logic [PrW-1:0] ey, logic [AbSqW-1:0] lim);
    logic [PrW:0] sum;
    sum = {1'b0, ex} + {1'b0, ey};
    return xok && yok && xbox && ybox &&
           (rect || (nz && (sum <= (PrW + 1)'(lim))));
  endfunction

  // points: 0 center, 1 right, 2 left, 3 below, 4 above
  always_comb begin
    s5_in_d[0] = pt_hit(s4_xok_q[1], s4_xbox_q[1], s4_yok_q[1], s4_ybox_q[1],
                        !shape_mode_q, axes_nz_q, s4_prx_q[1], s4_pry_q[1], ab_sq_q);
    s5_in_d[1] = pt_hit(s4_xok_q[2], s4_xbox_q[2], s4_yok_q[1], s4_ybox_q[1],
                        !shape_mode_q, axes_nz_q, s4_prx_q[2], s4_pry_q[1], ab_sq_q);
    s5_in_d[2] = pt_hit(s4_xok_q[0], s4_xbox_q[0], s4_yok_q[1], s4_ybox_q[1],
                        !shape_mode_q, axes_nz_q, s4_prx_q[0], s4_pry_q[1], ab_sq_q);
    s5_in_d[3] = pt_hit(s4_xok_q[1], s4_xbox_q[1], s4_yok_q[2], s4_ybox_q[2],
                        !shape_mode_q, axes_nz_q, s4_prx_q[1], s4_pry_q[2], ab_sq_q);
    s5_in_d[4] = pt_hit(s4_xok_q[1], s4_xbox_q[1], s4_yok_q[0], s4_ybox_q[0],
                        !shape_mode_q, axes_nz_q, s4_prx_q[1], s4_pry_q[0], ab_sq_q);
  end

  always_comb begin
    if (!s5_img_q) begin
      label_d = LabelOutside;
    end else if (s5_in_q[0]) begin
      label_d = LabelInside;
    end else if (|s5_in_q[4:1]) begin
      label_d = LabelBorder;
    end else begin
      label_d = LabelOutside;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_v_q <= start_i && !busy_o;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      done_q <= s5_v_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      s1_x_q <= pixel_x_i;
      s1_y_q <= pixel_y_i;
    end
    s2_xok_q  <= xok_d;
    s2_xbox_q <= xbox_d;
    s2_yok_q  <= yok_d;
    s2_ybox_q <= ybox_d;
    s3_xok_q  <= s2_xok_q;
    s3_xbox_q <= s2_xbox_q;
    s3_yok_q  <= s2_yok_q;
    s3_ybox_q <= s2_ybox_q;
    s4_xok_q  <= s3_xok_q;
    s4_xbox_q <= s3_xbox_q;
    s4_yok_q  <= s3_yok_q;
    s4_ybox_q <= s3_ybox_q;
    for (int i = 0; i < 3; i++) begin
      s2_adx_q[i] <= adx_d[i];
      s2_ady_q[i] <= ady_d[i];
      s3_sqx_q[i] <= s2_adx_q[i] * s2_adx_q[i];
      s3_sqy_q[i] <= s2_ady_q[i] * s2_ady_q[i];
      s4_prx_q[i] <= s3_sqx_q[i] * hb_sq_q;
      s4_pry_q[i] <= s3_sqy_q[i] * ha_sq_q;
    end
    s5_img_q <= s4_xok_q[1] && s4_yok_q[1];
    s5_in_q  <= s5_in_d;
    label_q  <= label_d;
  end

`ifndef SYNTH
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##6 done_o)
    else $error("accepted pixel produced no result");

  a_no_stray_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 6))
    else $error("result without a matching pixel");

  a_label_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (region_label_o == LabelOutside || region_label_o == LabelInside ||
                region_label_o == LabelBorder))
    else $error("illegal label code");

  a_inside_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s5_v_q && s5_in_q[0]) |-> s5_img_q)
    else $error("inside pixel outside the image");
`endif

endmodule
